// ----- hdl/pnlr_pkg.sv -----
// Shared types and constants for the PCM normalizing linear resampler.
// No dependencies; every other file in hdl/ imports this package.
package pnlr_pkg;

    localparam int RAW_W      = 16;   // raw channel sample bits
    localparam int SAMPLE_W   = 18;   // normalized sample, signed Q2.16
    localparam int CNT_W      = 24;   // output count and output_length
    localparam int STEP_W     = 24;   // step_increment, unsigned Q8.16
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // normalization divisors (2^k - 1) and their rounding halves
    localparam logic [15:0] DIV16     = 16'd32767;
    localparam logic [31:0] HALF16    = 32'd16383;
    localparam logic [7:0]  DIV8      = 8'd127;
    localparam logic [23:0] HALF8     = 24'd63;
    localparam logic [7:0]  OFFSET8   = 8'd127;

    // register reset values
    localparam logic                  FMT_RST  = 1'b0;
    localparam logic [1:0]            CHAN_RST = 2'd1;
    localparam logic [STEP_W-1:0]     STEP_RST = 24'd65536;
    localparam logic [CNT_W-1:0]      LEN_RST  = 24'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORMAT   = 2'd0,
        REG_CHANNELS = 2'd1,
        REG_STEP     = 2'd2,
        REG_LENGTH   = 2'd3
    } t_cfg_reg;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // take the input item
        logic norm;       // normalize, update history, load first run
        logic step;       // produce one interpolated output
        logic load_tail;  // load the wrap run (last sample, first sample)
        logic flush;      // send held result as last of the item
        logic clear;      // end of stream: state back to reset
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic more;       // current run has another output pending
        logic cand_v;     // a result is held in the staging register
        logic out_free;   // output register can take a result this cycle
        logic last;       // current item carries last_in
        logic kept_zero;  // no kept sample in the stream yet
    } t_status;

endpackage

// ----- hdl/pcm_normalize_linear_resampler.sv -----
// Top level of the PCM normalizing linear resampler.
// Instantiates pnlr_ctrl and pnlr_dp; types and constants from pnlr_pkg.

// Takes raw PCM items (16-bit signed or 8-bit unsigned in the low byte), keeps
// the first channel of each interleaved stereo pair, normalizes each kept
// sample to signed Q2.16 (s/32767 or (u-127)/127, rounded to nearest) and
// resamples by linear interpolation driven by a Q24.16 phase accumulator that
// advances by step_increment per output. Each kept sample closes the interval
// to the previous one and emits every pending output in it, at most
// MAX_UPSAMPLE per interval; on an item with last_in the last kept sample is
// paired with the first to emit the wrap interval, then the stream state
// returns to reset (registers are kept). Output stops after output_length
// outputs. end_of_run marks the last result of an item, end_of_stream the
// output that reaches output_length and the last result of a last_in item.
// Items are handled one at a time: after acceptance ready stays low while
// the sequencer steps through normalize, the interpolation runs and the
// final hand-off; each output takes one pass through the shared interpolator
// multiplier, and a last_in item adds a step to load the wrap interval;
// stalls on the output side hold the sequencer once a second result is
// waiting. Results leave through an output register, so a finished result
// may wait while work continues.
// Configuration writes are taken every cycle (ready is tied high) and must
// only be issued while the block is idle.
module pcm_normalize_linear_resampler #(
    parameter int COUNT_BITS   = 24,
    parameter int FRAC_BITS    = 16,
    parameter int MAX_UPSAMPLE = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input items
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [pnlr_pkg::RAW_W-1:0]             i_raw_sample,
    input  logic                                   i_last_in,
    // result items
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pnlr_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                                   o_end_of_run,
    output logic                                   o_end_of_stream,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pnlr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pnlr_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import pnlr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // register file never stalls
    assign o_cfg_ready = 1'b1;

    pnlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pnlr_dp #(
        .COUNT_BITS   (COUNT_BITS),
        .FRAC_BITS    (FRAC_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_raw_sample    (i_raw_sample),
        .i_last_in       (i_last_in),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_sample_out    (o_sample_out),
        .o_end_of_run    (o_end_of_run),
        .o_end_of_stream (o_end_of_stream)
    );

    // one item in flight: no new item right after one is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while previous item still in flight");

    // a held result is never overwritten while the output register is full
    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step && w_status.cand_v) |-> w_status.out_free)
        else $error("staged result would be lost");

    // outputs are only produced while the run still has pending phase
    a_step_only_when_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> w_status.more)
        else $error("output produced beyond the end of the run");

    // final hand-off only when the output register can take it
    a_flush_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.flush |-> (w_status.out_free && w_status.cand_v && !w_cmd.step))
        else $error("end-of-item result sent without room");

endmodule

// ----- hdl/pnlr_ctrl.sv -----
// Sequencer for the resampler: one item at a time through normalize, the
// interpolation runs and the final hand-off. Uses pnlr_pkg command/status types.
module pnlr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pnlr_pkg::t_status i_status,
    output pnlr_pkg::t_cmd    o_cmd
);
    import pnlr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NORM,
        S_RUN,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_tail, n_tail;    // running the wrap run

    always_comb begin
        n_state    = r_state;
        n_tail     = r_tail;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_tail     = 1'b0;
                n_state    = S_RUN;
            end
            S_RUN: begin
                priority if (i_status.more) begin
                    // a held result must leave before a new one replaces it
                    o_cmd.step = !i_status.cand_v || i_status.out_free;
                end else if (!r_tail && i_status.last && !i_status.kept_zero) begin
                    o_cmd.load_tail = 1'b1;
                    n_tail          = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_status.cand_v || i_status.out_free) begin
                    o_cmd.flush = i_status.cand_v;
                    o_cmd.clear = i_status.last;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tail  <= n_tail;
        end
    end

endmodule

// ----- hdl/pnlr_dp.sv -----
// Datapath of the resampler: config registers, normalizer, phase accumulator,
// interpolator, staging and output registers. Uses pnlr_pkg.
module pnlr_dp #(
    parameter int COUNT_BITS   = 24,
    parameter int FRAC_BITS    = 16,
    parameter int MAX_UPSAMPLE = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pnlr_pkg::t_cmd                         i_cmd,
    output pnlr_pkg::t_status                      o_status,
    input  logic                                   i_cfg_valid,
    input  logic [pnlr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pnlr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [pnlr_pkg::RAW_W-1:0]             i_raw_sample,
    input  logic                                   i_last_in,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [pnlr_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                                   o_end_of_run,
    output logic                                   o_end_of_stream
);
    import pnlr_pkg::*;

    localparam int PH_W   = COUNT_BITS + FRAC_BITS;
    localparam int SUM_W  = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
    localparam int MADE_W = $clog2(MAX_UPSAMPLE + 1);
    localparam int PROD_W = SAMPLE_W + 1 + FRAC_BITS + 1;
    localparam int RND_W  = PROD_W - FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF_F = PROD_W'(1) << (FRAC_BITS - 1);

    // configuration
    logic                r_fmt;
    logic [1:0]          r_chans;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W-1:0]    r_len;

    // stream state
    logic [RAW_W-1:0]           r_raw;
    logic                       r_last, r_keep, r_toggle, r_run_en;
    logic signed [SAMPLE_W-1:0] r_prev, r_first, r_a, r_b;
    logic [COUNT_BITS-1:0]      r_kept, r_limit;
    logic [PH_W-1:0]            r_phase;
    logic [CNT_W-1:0]           r_done;
    logic [MADE_W-1:0]          r_made;

    // staging and output
    logic signed [SAMPLE_W-1:0] r_cand, r_out_sample;
    logic                       r_cand_eos, r_cand_v;
    logic                       r_out_v, r_out_eor, r_out_eos;

    // normalizer
    logic [15:0] n16_mag;
    logic [31:0] n16_num;
    logic [16:0] n16_t;
    logic [17:0] n16_r;
    logic [2:0]  n16_t2;
    logic [15:0] n16_r2;
    logic [16:0] n16_q;
    logic        n8_neg;
    logic [7:0]  n8_mag;
    logic [23:0] n8_num;
    logic [16:0] n8_t;
    logic [17:0] n8_r;
    logic [10:0] n8_t2;
    logic [11:0] n8_r2;
    logic [4:0]  n8_t3;
    logic [7:0]  n8_r3;
    logic [16:0] n8_q;
    logic [16:0] norm_q;
    logic        norm_neg;
    logic signed [SAMPLE_W-1:0] cur;

    // interpolator and counters
    logic signed [SAMPLE_W:0]   diff;
    logic signed [FRAC_BITS:0]  frac;
    logic signed [PROD_W-1:0]   prod, rnd;
    logic signed [RND_W-1:0]    corr, interp_w;
    logic signed [SAMPLE_W-1:0] interp;
    logic [SUM_W-1:0]           ph_sum;
    logic [PH_W-1:0]            ph_next;
    logic [CNT_W-1:0]           done_next;
    logic [COUNT_BITS-1:0]      kept_next;

    // Division by 2^k - 1 folds the high part back onto the low part:
    // N = t*2^k + lo = t*(2^k - 1) + (t + lo); repeat until one compare is left.
    always_comb begin
        n16_mag = r_raw[15] ? (16'd0 - r_raw) : r_raw;
        n16_num = {n16_mag, 16'd0} + HALF16;
        n16_t   = n16_num[31:15];
        n16_r   = 18'(n16_num[14:0]) + 18'(n16_t);
        n16_t2  = n16_r[17:15];
        n16_r2  = 16'(n16_r[14:0]) + 16'(n16_t2);
        n16_q   = n16_t + 17'(n16_t2) + 17'(n16_r2 >= DIV16);

        n8_neg  = r_raw[7:0] < OFFSET8;
        n8_mag  = n8_neg ? (OFFSET8 - r_raw[7:0]) : (r_raw[7:0] - OFFSET8);
        n8_num  = {n8_mag, 16'd0} + HALF8;
        n8_t    = n8_num[23:7];
        n8_r    = 18'(n8_num[6:0]) + 18'(n8_t);
        n8_t2   = n8_r[17:7];
        n8_r2   = 12'(n8_r[6:0]) + 12'(n8_t2);
        n8_t3   = n8_r2[11:7];
        n8_r3   = 8'(n8_r2[6:0]) + 8'(n8_t3);
        n8_q    = n8_t + 17'(n8_t2) + 17'(n8_t3) + 17'(n8_r3 >= DIV8);

        norm_q   = r_fmt ? n8_q : n16_q;
        norm_neg = r_fmt ? n8_neg : r_raw[15];
        cur      = norm_neg ? $signed(18'd0 - {1'b0, norm_q}) : $signed({1'b0, norm_q});
    end

    // a + round((b - a) * frac), ties toward plus infinity
    always_comb begin
        diff     = {r_b[SAMPLE_W-1], r_b} - {r_a[SAMPLE_W-1], r_a};
        frac     = {1'b0, r_phase[FRAC_BITS-1:0]};
        prod     = PROD_W'(diff) * PROD_W'(frac);
        rnd      = prod + $signed(HALF_F);
        corr     = rnd[PROD_W-1:FRAC_BITS];
        interp_w = RND_W'(r_a) + corr;
        interp   = interp_w[SAMPLE_W-1:0];
    end

    always_comb begin
        ph_sum    = SUM_W'(r_phase) + SUM_W'(r_step);
        ph_next   = (|ph_sum[SUM_W-1:PH_W]) ? {PH_W{1'b1}} : ph_sum[PH_W-1:0];
        done_next = r_done + CNT_W'(1);
        kept_next = (&r_kept) ? r_kept : r_kept + COUNT_BITS'(1);
    end

    always_comb begin
        o_status.more      = r_run_en && (r_made < MADE_W'(MAX_UPSAMPLE))
                             && (r_done < r_len)
                             && (r_phase[PH_W-1:FRAC_BITS] <= r_limit);
        o_status.cand_v    = r_cand_v;
        o_status.out_free  = !r_out_v || i_out_ready;
        o_status.last      = r_last;
        o_status.kept_zero = (r_kept == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_RST;
            r_chans <= CHAN_RST;
            r_step  <= STEP_RST;
            r_len   <= LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FORMAT:   r_fmt   <= i_cfg_data[0];
                REG_CHANNELS: r_chans <= i_cfg_data[1:0];
                REG_STEP:     r_step  <= i_cfg_data[STEP_W-1:0];
                REG_LENGTH:   r_len   <= i_cfg_data[CNT_W-1:0];
                default:      r_fmt   <= r_fmt;
            endcase
        end
    end

    // control and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b0;
            r_keep   <= 1'b0;
            r_toggle <= 1'b0;
            r_run_en <= 1'b0;
            r_prev   <= '0;
            r_first  <= '0;
            r_kept   <= '0;
            r_phase  <= '0;
            r_done   <= '0;
            r_made   <= '0;
            r_cand_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_last <= i_last_in;
                if (r_chans[1]) begin
                    r_keep   <= !r_toggle;
                    r_toggle <= !r_toggle;
                end else begin
                    r_keep   <= 1'b1;
                    r_toggle <= 1'b0;
                end
            end
            if (i_cmd.norm) begin
                r_run_en <= r_keep && (r_kept != '0);
                r_made   <= '0;
                if (r_keep) begin
                    r_prev <= cur;
                    r_kept <= kept_next;
                    if (r_kept == '0) begin
                        r_first <= cur;
                    end
                end
            end
            if (i_cmd.step) begin
                r_cand_v <= 1'b1;
                r_done   <= done_next;
                r_phase  <= ph_next;
                r_made   <= r_made + MADE_W'(1);
            end
            if (i_cmd.load_tail) begin
                r_run_en <= 1'b1;
                r_made   <= '0;
            end
            if (i_cmd.flush) begin
                r_cand_v <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_prev   <= '0;
                r_first  <= '0;
                r_kept   <= '0;
                r_phase  <= '0;
                r_done   <= '0;
                r_toggle <= 1'b0;
                r_run_en <= 1'b0;
            end
            if ((i_cmd.step && r_cand_v) || i_cmd.flush) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw <= i_raw_sample;
        end
        if (i_cmd.norm) begin
            r_a     <= r_prev;
            r_b     <= cur;
            r_limit <= r_kept - COUNT_BITS'(1);
        end
        if (i_cmd.load_tail) begin
            r_a     <= r_prev;
            r_b     <= r_first;
            r_limit <= r_kept - COUNT_BITS'(1);
        end
        if (i_cmd.step) begin
            r_cand     <= interp;
            r_cand_eos <= (done_next == r_len);
        end
        if ((i_cmd.step && r_cand_v) || i_cmd.flush) begin
            r_out_sample <= r_cand;
            r_out_eor    <= i_cmd.flush;
            r_out_eos    <= r_cand_eos || (i_cmd.flush && r_last);
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_sample_out    = r_out_sample;
    assign o_end_of_run    = r_out_eor;
    assign o_end_of_stream = r_out_eos;

endmodule

// ----- tb/tb_pcm_normalize_linear_resampler.sv -----
// Self-checking testbench for pcm_normalize_linear_resampler: directed and random
// streams of raw PCM items, with results checked against an in-bench predictor.
// Depends on hdl/pnlr_pkg.sv and hdl/pcm_normalize_linear_resampler.sv.
`timescale 1ns / 100ps

module tb_pcm_normalize_linear_resampler;
    import pnlr_pkg::*;

    localparam int FRAC       = 16;        // phase fraction bits
    localparam int MAX_RUN    = 32;        // outputs per interval, at most
    localparam int QUIET_MAX  = 4000;      // cycles with no handshake before giving up
    localparam int HOLD_LEN   = 400;       // long receiver hold-off
    localparam int SETTLE     = 16;        // idle cycles before a register write
    localparam logic [39:0] PHASE_TOP = 40'hFF_FFFF_FFFF;
    localparam logic [23:0] KEPT_TOP  = 24'hFF_FFFF;

    // one raw item as offered to the block
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             is_last;
    } t_pcm_item;

    // one resampled result as expected from the block
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       eor;
        logic                       eos;
    } t_resampled;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [RAW_W-1:0]           i_raw_sample = '0;
    logic                       i_last_in = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_end_of_run;
    logic                       o_end_of_stream;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    pcm_normalize_linear_resampler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_raw_sample    (i_raw_sample),
        .i_last_in       (i_last_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample_out    (o_sample_out),
        .o_end_of_run    (o_end_of_run),
        .o_end_of_stream (o_end_of_stream),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of the registers and the stream state.
    // Registers start at their reset values; the stream state at zero.
    // ------------------------------------------------------------------
    logic                       cfg_fmt  = FMT_RST;
    logic [1:0]                 cfg_chan = CHAN_RST;
    logic [STEP_W-1:0]          cfg_step = STEP_RST;
    logic [CNT_W-1:0]           cfg_len  = LEN_RST;

    logic signed [SAMPLE_W-1:0] prev_norm  = '0;   // most recent kept sample
    logic signed [SAMPLE_W-1:0] first_norm = '0;   // first kept sample, used on wrap
    logic [23:0]                kept_cnt   = '0;
    logic [39:0]                phase_acc  = '0;   // Q24.16
    logic [CNT_W-1:0]           out_cnt    = '0;
    logic                       odd_chan   = 1'b0; // stereo: next item is right channel

    t_resampled                 span_buf[2*MAX_RUN];
    int                         span_n;
    t_resampled                 resampled_q[$];    // results still owed by the block
    t_pcm_item                  raw_pending[$];    // items not yet offered

    int mismatch_cnt = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int cfg_writes   = 0;

    // raw bits -> Q2.16, rounded to nearest
    function automatic logic signed [SAMPLE_W-1:0] norm_sample(logic [RAW_W-1:0] raw);
        longint x;
        longint d;
        longint mag;
        longint q;
        if (cfg_fmt) begin
            x = longint'(raw[7:0]) - 127;   // high byte ignored in 8-bit mode
            d = 127;
        end else begin
            x = longint'($signed(raw));
            d = 32767;
        end
        mag = (x < 0 ? -x : x) << FRAC;
        q = (mag + d / 2) / d;
        return SAMPLE_W'((x < 0) ? -q : q);
    endfunction

    // a + (b-a)*frac, product rounded with ties toward +inf (floor of p + half)
    function automatic longint lerp(longint a, longint b, longint frac);
        longint p;
        p = (b - a) * frac;
        return a + ((p + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    endfunction

    // every pending output with integer phase <= upto, paired (a, b)
    function automatic void emit_span(longint a, longint b, logic [23:0] upto);
        int     made;
        longint v;
        made = 0;
        while (made < MAX_RUN && out_cnt < cfg_len && (phase_acc >> FRAC) <= {16'd0, upto}) begin
            v = lerp(a, b, longint'(phase_acc[FRAC-1:0]));
            out_cnt = out_cnt + CNT_W'(1);
            span_buf[span_n].sample = v[SAMPLE_W-1:0];
            span_buf[span_n].eor    = 1'b0;
            span_buf[span_n].eos    = (out_cnt == cfg_len);
            span_n++;
            if (PHASE_TOP - phase_acc < {16'd0, cfg_step}) phase_acc = PHASE_TOP;
            else phase_acc = phase_acc + {16'd0, cfg_step};
            made++;
        end
    endfunction

    // advance the predictor by one accepted item and queue its results
    function automatic void predict_item(logic [RAW_W-1:0] raw, logic is_last);
        logic                       keep_it;
        logic signed [SAMPLE_W-1:0] cur;
        keep_it = 1'b1;
        span_n  = 0;
        if (cfg_chan >= 2'd2) begin
            keep_it  = !odd_chan;
            odd_chan = !odd_chan;
        end else begin
            odd_chan = 1'b0;
        end
        if (keep_it) begin
            cur = norm_sample(raw);
            if (kept_cnt == 0) first_norm = cur;
            else emit_span(prev_norm, cur, kept_cnt - 24'd1);
            prev_norm = cur;
            if (kept_cnt != KEPT_TOP) kept_cnt = kept_cnt + 24'd1;
        end
        if (is_last) begin
            // wrap interval: last kept sample back to the first
            if (kept_cnt != 0) emit_span(prev_norm, first_norm, kept_cnt - 24'd1);
            if (span_n > 0) span_buf[span_n-1].eos = 1'b1;
            prev_norm  = '0;
            first_norm = '0;
            kept_cnt   = '0;
            phase_acc  = '0;
            out_cnt    = '0;
            odd_chan   = 1'b0;
        end
        if (span_n > 0) span_buf[span_n-1].eor = 1'b1;
        for (int i = 0; i < span_n; i++) resampled_q.push_back(span_buf[i]);
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Traffic shaping: idle percentages are set per phase by the stimulus.
    // ------------------------------------------------------------------
    int   send_idle_pct = 31;
    int   recv_idle_pct = 50;
    logic hold_arm  = 1'b0;
    logic hold_used = 1'b0;
    int   hold_left = 0;

    // one long receiver hold-off, counted here once armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_arm && !hold_used) begin
            hold_left <= HOLD_LEN;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Driver: predicts on acceptance, then offers the next pending item.
    // valid stays up with a stable payload until the item is taken.
    t_pcm_item next_item;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_item(i_raw_sample, i_last_in);
                items_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (raw_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_item = raw_pending.pop_front();
                    i_in_valid   <= 1'b1;
                    i_raw_sample <= next_item.raw;
                    i_last_in    <= next_item.is_last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: each taken result against the oldest owed one
    t_resampled want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (resampled_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result sample=%0d eor=%0b eos=%0b",
                                          o_sample_out, o_end_of_run, o_end_of_stream));
            end else begin
                want = resampled_q.pop_front();
                if (o_sample_out !== want.sample)
                    report_mismatch($sformatf("sample_out %0d, expected %0d",
                                              o_sample_out, want.sample));
                if (o_end_of_run !== want.eor)
                    report_mismatch($sformatf("end_of_run %0b, expected %0b",
                                              o_end_of_run, want.eor));
                if (o_end_of_stream !== want.eos)
                    report_mismatch($sformatf("end_of_stream %0b, expected %0b",
                                              o_end_of_stream, want.eos));
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                     || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("timeout: no handshake for %0d cycles, %0d results owed",
                     QUIET_MAX, resampled_q.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_FORMAT:   cfg_fmt  = val[0];
            REG_CHANNELS: cfg_chan = val[1:0];
            REG_STEP:     cfg_step = val;
            REG_LENGTH:   cfg_len  = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(logic fmt, logic [1:0] chan, logic [23:0] step,
                              logic [23:0] len);
        write_reg(REG_FORMAT, {23'd0, fmt});
        write_reg(REG_CHANNELS, {22'd0, chan});
        write_reg(REG_STEP, step);
        write_reg(REG_LENGTH, len);
    endtask

    task automatic push_item(logic [RAW_W-1:0] raw, logic is_last);
        t_pcm_item it;
        it.raw     = raw;
        it.is_last = is_last;
        raw_pending.push_back(it);
    endtask

    // mostly uniform bits, now and then a full-scale or midpoint code
    function automatic logic [RAW_W-1:0] pick_raw();
        if ($urandom_range(0, 7) != 0) return RAW_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            4: return 16'h00FF;
            default: return 16'h007F;
        endcase
    endfunction

    // a stream of n items closed by last_in; a stray last_in now and then
    task automatic queue_stream(int n);
        for (int i = 0; i < n; i++)
            push_item(pick_raw(), (i == n - 1) || ($urandom_range(0, 19) == 0));
    endtask

    // everything offered, taken and answered, then let an empty-result item drain
    task automatic wait_idle();
        do @(posedge i_clk);
        while (raw_pending.size() != 0 || i_in_valid || resampled_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic        rfmt;
        logic [1:0]  rchan;
        logic [23:0] rstep;
        logic [23:0] rlen;
        int          n_in;
        int          slen;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: output_length 0, so nothing may come out
        @(negedge i_clk);
        push_item(16'h1234, 1'b0);
        push_item(16'hFEDC, 1'b1);
        wait_idle();

        // 16-bit mono, upsampling by 8/3: full-scale codes, then a lone sample
        // that wraps onto itself
        set_config(1'b0, 2'd1, 24'd24576, 24'd1000);
        @(negedge i_clk);
        push_item(16'h7FFF, 1'b0);
        push_item(16'h8000, 1'b0);
        push_item(16'h0001, 1'b0);
        push_item(16'hFFFF, 1'b0);
        push_item(16'h0000, 1'b1);
        push_item(16'h4000, 1'b1);
        wait_idle();

        // 8-bit, channel_count 0 (mono), step 1/32: 32 outputs per interval,
        // the last item fills a full run plus the wrap run; high byte ignored
        set_config(1'b1, 2'd0, 24'd2048, 24'hFF_FFFF);
        @(negedge i_clk);
        push_item(16'h0000, 1'b0);
        push_item(16'h00FF, 1'b0);
        push_item(16'h007F, 1'b0);
        push_item(16'hAB80, 1'b1);
        wait_idle();

        // stereo at maximum step; last_in lands on a dropped right-channel item
        set_config(1'b0, 2'd2, 24'hFF_FFFF, 24'd50);
        @(negedge i_clk);
        push_item(16'h1111, 1'b0);
        push_item(16'h2222, 1'b0);
        push_item(16'h8000, 1'b0);
        push_item(16'h3333, 1'b0);
        push_item(16'h7FFF, 1'b0);
        push_item(16'h4444, 1'b1);
        // leave a stream open across a register change
        push_item(16'h0100, 1'b0);
        push_item(16'h0200, 1'b0);
        wait_idle();

        // mid-stream: zero step (phase frozen), length cut short at 40
        set_config(1'b0, 2'd3, 24'd0, 24'd40);
        @(negedge i_clk);
        push_item(16'h0300, 1'b0);
        push_item(16'h0400, 1'b0);
        push_item(16'h0500, 1'b1);
        wait_idle();

        // Random phases: receiver-heavy idling, then sender-heavy, then none.
        // The no-idle stretch opens with a long receiver hold-off so the block
        // backs up and stalls its input.
        for (int ph = 0; ph < 9; ph++) begin
            rfmt  = 1'($urandom_range(0, 1));
            rchan = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       rstep = 24'd2048;
                1:       rstep = 24'hFF_FFFF;
                2:       rstep = 24'($urandom_range(0, 2047));
                default: rstep = 24'($urandom_range(4096, 150000));
            endcase
            case ($urandom_range(0, 7))
                0:       rlen = 24'hFF_FFFF;
                1:       rlen = 24'($urandom_range(0, 3));
                default: rlen = 24'($urandom_range(8, 400));
            endcase
            // the hold-off stretch needs results to back up
            if (ph == 6) rlen = 24'hFF_FFFF;
            set_config(rfmt, rchan, rstep, rlen);

            @(negedge i_clk);
            if (ph == 3) begin
                send_idle_pct = 50;
                recv_idle_pct = 31;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_arm      = 1'b1;
            end
            n_in = 0;
            while (n_in < 45) begin
                slen = $urandom_range(1, 10);
                queue_stream(slen);
                n_in += slen;
            end
            wait_idle();
        end

        repeat (40) @(posedge i_clk);

        $display("Ran %0d input items and checked %0d resampled results over %0d register writes,",
                 items_taken, results_seen, cfg_writes);
        $display("covering both sample formats, mono and stereo, and step and length extremes.");
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pnlr_pkg.sv
hdl/pnlr_ctrl.sv
hdl/pnlr_dp.sv
hdl/pcm_normalize_linear_resampler.sv
tb/tb_pcm_normalize_linear_resampler.sv
